[rtl/core/ckim_pkg.sv]
// Shared types and constants for the colour key to index mapper.
package ckim_pkg;

  localparam int COLOUR_W = 24;
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_LOCK  = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_LOCKED    = 3'd1,
    STAT_NOTLOCKED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_BADCOLOUR = 3'd4,
    STAT_DUPLICATE = 3'd5,
    STAT_UNKNOWN   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_clear;
    logic clear_done;
  } dp_status_t;

endpackage

[rtl/core/ckim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ckim_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/ckim_ctrl.sv]
// Control state machine: accept, key scan, result write-back, seen clear.
module ckim_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ckim_pkg::ctrl_cmd_t    cmd,
  input  ckim_pkg::dp_status_t   sts
);
  import ckim_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          if (sts.need_clear) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ckim_dpath.sv]
// Datapath: key table, sequential key search, seen marks and result registers.
module ckim_dpath #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ckim_pkg::ctrl_cmd_t             cmd,
  output ckim_pkg::dp_status_t            sts,
  input  logic [1:0]                      command,
  input  logic [ckim_pkg::COLOUR_W-1:0]   colour,
  input  logic                            last_pixel,
  output logic [ckim_pkg::STATUS_W-1:0]   status,
  output logic [ckim_pkg::IDX_W-1:0]      index,
  output logic [ckim_pkg::IDX_W-1:0]      missing_count,
  output logic                            frame_end
);
  import ckim_pkg::*;

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W  = CNT_W + IDX_W;

  // latched beat
  cmd_t                cmd_r;
  logic [COLOUR_W-1:0] colour_r;
  logic                last_r;

  // table state
  logic [CNT_W-1:0]       count;
  logic                   locked;
  logic [CNT_W-1:0]       seen_cnt;

  // search
  logic [CNT_W-1:0]    ptr;
  logic                rd_pend;
  logic [ADDR_W-1:0]   rd_idx;
  logic                found;
  logic [ADDR_W-1:0]   hit;
  logic                hit_seen;
  logic                issue;
  logic                clr_issue;
  logic                match;
  logic [COLOUR_W-1:0] ram_q;
  logic                seen_q;

  // write-back
  logic                ram_we;
  logic                seen_we;
  logic [ADDR_W-1:0]   seen_waddr;
  logic                seen_wdata;
  status_t             res_status;
  logic [CNT_W-1:0]    res_index;
  logic [CNT_W-1:0]    res_missing;
  logic                res_fend;
  logic                mark;
  logic                clear_seen;
  logic [CNT_W-1:0]    seen_cnt_new;
  logic [EXT_W-1:0]    index_ext;
  logic [EXT_W-1:0]    missing_ext;

  assign issue          = cmd.scan && (ptr < count);
  assign clr_issue      = cmd.clear && (ptr < count);
  assign match          = rd_pend && (ram_q == colour_r);
  assign sts.scan_done  = match || (!issue && !rd_pend);
  assign sts.need_clear = clear_seen;
  assign sts.clear_done = (ptr + CNT_W'(1)) >= count;

  ckim_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (colour_r),
    .rd_addr (ptr[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  // seen marks, read alongside the keys during the scan
  ckim_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ENTRIES)
  ) u_seen_ram (
    .clk     (clk),
    .wr_en   (seen_we),
    .wr_addr (seen_waddr),
    .wr_data (seen_wdata),
    .rd_addr (ptr[ADDR_W-1:0]),
    .rd_data (seen_q)
  );

  always_comb begin
    ram_we       = 1'b0;
    res_status   = STAT_OK;
    res_index    = '0;
    res_missing  = '0;
    res_fend     = 1'b0;
    mark         = 1'b0;
    clear_seen   = 1'b0;
    seen_cnt_new = seen_cnt;
    unique case (cmd_r)
      CMD_ADD: begin
        priority if (locked) begin
          res_status = STAT_LOCKED;
        end else if (count >= CNT_W'(MAX_ENTRIES)) begin
          res_status = STAT_FULL;
        end else if (colour_r == '0) begin
          res_status = STAT_BADCOLOUR;
        end else if (found) begin
          res_status = STAT_DUPLICATE;
        end else begin
          ram_we    = cmd.finish;
          res_index = count + CNT_W'(1);
        end
      end
      CMD_LOCK: begin
        res_status = STAT_OK;
      end
      CMD_PIXEL: begin
        if (!locked) begin
          res_status = STAT_NOTLOCKED;
        end else begin
          if (colour_r != '0) begin
            if (found) begin
              res_index = CNT_W'(hit) + CNT_W'(1);
              mark      = 1'b1;
              if (!hit_seen) begin
                seen_cnt_new = seen_cnt + CNT_W'(1);
              end
            end else begin
              res_status = STAT_UNKNOWN;
            end
          end
          if (last_r) begin
            res_fend    = 1'b1;
            res_missing = count - seen_cnt_new;
            clear_seen  = 1'b1;
          end
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // new keys start unseen; hits mark; the clear pass wipes entries below count
  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = ptr[ADDR_W-1:0];
    seen_wdata = 1'b0;
    if (cmd.clear) begin
      seen_we = clr_issue;
    end else if (cmd.finish) begin
      if (ram_we) begin
        seen_we    = 1'b1;
        seen_waddr = count[ADDR_W-1:0];
      end else if (mark) begin
        seen_we    = 1'b1;
        seen_waddr = hit;
        seen_wdata = 1'b1;
      end
    end
  end

  assign index_ext   = EXT_W'(res_index);
  assign missing_ext = EXT_W'(res_missing);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r    <= cmd_t'(command);
      colour_r <= colour;
      last_r   <= last_pixel;
    end
    if (cmd.scan && match) begin
      hit      <= rd_idx;
      hit_seen <= seen_q;
    end
    rd_idx <= ptr[ADDR_W-1:0];
    if (cmd.finish) begin
      status        <= res_status;
      index         <= index_ext[IDX_W-1:0];
      missing_count <= missing_ext[IDX_W-1:0];
      frame_end     <= res_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
      count    <= '0;
      locked   <= 1'b0;
      seen_cnt <= '0;
    end else begin
      if (cmd.start) begin
        ptr     <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
      end else begin
        rd_pend <= issue;
        if (cmd.finish) begin
          ptr <= '0;
        end else if (issue || clr_issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        if (cmd.scan && match) begin
          found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (ram_we) begin
          count <= count + CNT_W'(1);
        end
        if (cmd_r == CMD_LOCK) begin
          locked <= 1'b1;
        end
        if (clear_seen) begin
          seen_cnt <= '0;
        end else begin
          seen_cnt <= seen_cnt_new;
        end
      end
    end
  end

endmodule

[rtl/core/colour_key_to_index_mapper.sv]
// Colour key to index mapper top level.
// Usage:
//   Input channel (in_valid/in_stall) carries command, colour and last_pixel.
//   Commands: add a key colour, lock the table, map a pixel colour.
//   Output channel (out_valid/out_stall) returns one result beat per input
//   beat: status, index, missing_count and frame_end.
//   Each beat is looked up by a sequential scan of the key RAM, one stored
//   key per cycle. A last pixel after lock adds a pass that clears one seen
//   mark per cycle, with the input stalled.
//   The next beat is accepted in the cycle after the result is registered,
//   or after the clear pass.
//   The result sits in an output register; while the receiver stalls it
//   holds, and a new beat may be taken and scanned, but its write-back waits
//   until the output register is free.
//   Reset (synchronous, active high) empties the table, unlocks it and drops
//   out_valid. Neither RAM is cleared: a key's seen mark is cleared when the
//   key is added, and only entries below the entry count are ever read.
module colour_key_to_index_mapper #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic [ckim_pkg::COLOUR_W-1:0]   colour,
  input  logic                            last_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ckim_pkg::STATUS_W-1:0]   status,
  output logic [ckim_pkg::IDX_W-1:0]      index,
  output logic [ckim_pkg::IDX_W-1:0]      missing_count,
  output logic                            frame_end
);
  import ckim_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ckim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ckim_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .command       (command),
    .colour        (colour),
    .last_pixel    (last_pixel),
    .status        (status),
    .index         (index),
    .missing_count (missing_count),
    .frame_end     (frame_end)
  );

endmodule
